>>> rtl/cfr_pkg.sv
// Package for the CRC-16 command framer: job record passed from front to back,
// framing constants and the byte-wise CRC-16/CCITT-FALSE update.
// No dependencies.
package cfr_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_TOP  = 16'h8000;
   localparam logic [15:0] CRC_POLY = 16'h1021;

   localparam logic [7:0] SYNC_A  = 8'hAA;
   localparam logic [7:0] SYNC_B  = 8'h55;
   localparam logic [7:0] SYNC_C  = 8'h00;
   localparam logic [7:0] TAIL_CR = 8'h0D;
   localparam logic [7:0] TAIL_LF = 8'h0A;

   localparam int          LEN_W       = 6;
   localparam logic [LEN_W-1:0] MAX_PAYLOAD = LEN_W'(62);

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // One classified item: which parts of the packet it produces.
   typedef struct packed {
      logic             first;     // emits header and header CRC
      logic             has_data;  // emits one payload byte
      logic             last;      // emits trailer CRC and CR LF
      logic [7:0]       cmd;
      logic [LEN_W-1:0] len;
      logic [7:0]       data;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } push_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } head_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
      logic [15:0] c;
      c = crc_in ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

>>> rtl/cfr_if.sv
// Valid/ready channels of the framer: request beats in, packet bytes out.
// Depends on cfr_pkg for the length width.
interface cfr_req_if;
   logic                     valid;
   logic                     ready;
   logic [7:0]               command_code;
   logic [cfr_pkg::LEN_W-1:0] payload_length;
   logic [7:0]               data_byte;

   modport source (output valid, output command_code, output payload_length,
                   output data_byte, input ready);
   modport sink   (input valid, input command_code, input payload_length,
                   input data_byte, output ready);
endinterface

interface cfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       end_of_packet;

   modport source (output valid, output out_byte, output end_of_packet, input ready);
   modport sink   (input valid, input out_byte, input end_of_packet, output ready);
endinterface

>>> rtl/cfr_front.sv
// Front end: accepts request beats, tracks packet framing and classifies each
// beat into a job for the queue. Depends on cfr_pkg and cfr_req_if.
module cfr_front (
   input  logic              clock,
   input  logic              reset,
   cfr_req_if.sink           req_ch,
   input  logic              queue_full,
   output cfr_pkg::push_type push
);

   logic                      open_ff, open_in;
   logic [cfr_pkg::LEN_W-1:0] remain_ff, remain_in;
   logic [cfr_pkg::LEN_W-1:0] len_sat;
   logic                      take;

   assign req_ch.ready = !queue_full;
   assign take         = req_ch.valid && !queue_full;

   always_comb begin
      len_sat = (req_ch.payload_length > cfr_pkg::MAX_PAYLOAD) ?
                cfr_pkg::MAX_PAYLOAD : req_ch.payload_length;
      push.valid    = take;
      push.job.cmd  = req_ch.command_code;
      push.job.data = req_ch.data_byte;
      open_in       = open_ff;
      remain_in     = remain_ff;
      if (!open_ff) begin
         push.job.first    = 1'b1;
         push.job.len      = len_sat;
         push.job.has_data = (len_sat != '0);
         push.job.last     = (len_sat <= cfr_pkg::LEN_W'(1));
         if (take) begin
            open_in   = (len_sat > cfr_pkg::LEN_W'(1));
            remain_in = len_sat - cfr_pkg::LEN_W'(1);
         end
      end else begin
         // remaining count is never zero while a packet is open
         push.job.first    = 1'b0;
         push.job.len      = remain_ff;
         push.job.has_data = 1'b1;
         push.job.last     = (remain_ff == cfr_pkg::LEN_W'(1));
         if (take) begin
            open_in   = (remain_ff != cfr_pkg::LEN_W'(1));
            remain_in = remain_ff - cfr_pkg::LEN_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         remain_ff <= '0;
      end else begin
         open_ff   <= open_in;
         remain_ff <= remain_in;
      end
   end

endmodule

>>> rtl/cfr_queue.sv
// Short job queue between front and back so each side can stall on its own.
// Depends on cfr_pkg.
module cfr_queue (
   input  logic              clock,
   input  logic              reset,
   input  cfr_pkg::push_type push,
   input  logic              pop,
   output logic              full,
   output cfr_pkg::head_type head
);

   localparam int CNT_W = cfr_pkg::QPTR_W + 1;

   cfr_pkg::job_type          slot_ff [cfr_pkg::QUEUE_DEPTH];
   logic [cfr_pkg::QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]           count_ff;
   logic                       do_push, do_pop;

   assign full       = (count_ff == CNT_W'(cfr_pkg::QUEUE_DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.job   = slot_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (!do_push && do_pop) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

>>> rtl/cfr_back.sv
// Back end: walks each job through its packet bytes, one byte per beat,
// folds every byte but the final LF into the running CRC and drives the output register.
// Depends on cfr_pkg and cfr_rsp_if.
module cfr_back (
   input  logic              clock,
   input  logic              reset,
   input  cfr_pkg::head_type head,
   output logic              pop,
   cfr_rsp_if.source         rsp_ch
);

   typedef enum logic [3:0] {
      S_SYNC_A, S_SYNC_B, S_SYNC_C, S_CMD, S_LEN_HI, S_LEN_LO,
      S_HCRC_HI, S_HCRC_LO, S_DATA, S_TCRC_HI, S_TCRC_LO, S_CR, S_LF
   } step_type;

   step_type         step_ff, step_in;
   logic             busy_ff;
   cfr_pkg::job_type job_ff;
   logic [15:0]      crc_ff, crc_cur;
   logic [7:0]       snap_ff;
   logic             out_valid_ff;
   logic [7:0]       out_byte_ff;
   logic             eop_ff;
   logic [7:0]       byte_val;
   logic             done;
   logic             advance;
   logic             load;

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.out_byte      = out_byte_ff;
   assign rsp_ch.end_of_packet = eop_ff;

   assign advance = busy_ff && (!out_valid_ff || rsp_ch.ready);
   assign load    = (!busy_ff || (advance && done)) && head.valid;
   assign pop     = load;

   always_comb begin
      crc_cur  = (step_ff == S_SYNC_A) ? cfr_pkg::CRC_INIT : crc_ff;
      byte_val = 8'h00;
      step_in  = step_ff;
      done     = 1'b0;
      unique case (step_ff)
         S_SYNC_A:  begin byte_val = cfr_pkg::SYNC_A; step_in = S_SYNC_B;  end
         S_SYNC_B:  begin byte_val = cfr_pkg::SYNC_B; step_in = S_SYNC_C;  end
         S_SYNC_C:  begin byte_val = cfr_pkg::SYNC_C; step_in = S_CMD;     end
         S_CMD:     begin byte_val = job_ff.cmd;      step_in = S_LEN_HI;  end
         // length never reaches the high byte
         S_LEN_HI:  begin byte_val = 8'h00;           step_in = S_LEN_LO;  end
         S_LEN_LO:  begin byte_val = 8'(job_ff.len);  step_in = S_HCRC_HI; end
         S_HCRC_HI: begin byte_val = crc_cur[15:8];   step_in = S_HCRC_LO; end
         S_HCRC_LO: begin
            byte_val = snap_ff;
            step_in  = job_ff.has_data ? S_DATA : S_TCRC_HI;
         end
         S_DATA: begin
            byte_val = job_ff.data;
            step_in  = S_TCRC_HI;
            done     = !job_ff.last;
         end
         S_TCRC_HI: begin byte_val = crc_cur[15:8];   step_in = S_TCRC_LO; end
         S_TCRC_LO: begin byte_val = snap_ff;         step_in = S_CR;      end
         S_CR:      begin byte_val = cfr_pkg::TAIL_CR; step_in = S_LF;     end
         S_LF:      begin byte_val = cfr_pkg::TAIL_LF; done = 1'b1;        end
         default:   begin byte_val = 8'h00;           done = 1'b1;         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
         step_ff      <= S_SYNC_A;
         crc_ff       <= cfr_pkg::CRC_INIT;
      end else begin
         if (advance)           out_valid_ff <= 1'b1;
         else if (rsp_ch.ready) out_valid_ff <= 1'b0;
         if (advance) begin
            out_byte_ff  <= byte_val;
            eop_ff       <= (step_ff == S_LF);
            crc_ff       <= (step_ff == S_LF) ? cfr_pkg::CRC_INIT
                                              : cfr_pkg::crc_byte(crc_cur, byte_val);
            // CRC high byte goes out first; low byte comes from the value before it
            if (step_ff == S_HCRC_HI || step_ff == S_TCRC_HI) snap_ff <= crc_cur[7:0];
         end
         if (load) begin
            busy_ff <= 1'b1;
            job_ff  <= head.job;
            step_ff <= head.job.first ? S_SYNC_A : S_DATA;
         end else if (advance) begin
            if (done) busy_ff <= 1'b0;
            else      step_ff <= step_in;
         end
      end
   end

endmodule

>>> rtl/crc16_command_framer_unit.sv
// An item's first output byte passes the job queue, the back end's job register and the
// output register. Throughput: one output byte per cycle while rsp_ch is ready; each
// beat gives its data byte, if any; a first adds header and CRC, a last CRC and CR LF.
// A 4-deep job queue lets request beats keep arriving during header and trailer bursts.
// Reset (synchronous, active high) empties the queue and closes any open packet.
module crc16_command_framer_unit (
   input  logic       clock,
   input  logic       reset,
   cfr_req_if.sink    req_ch,
   cfr_rsp_if.source  rsp_ch
);

   cfr_pkg::push_type push;
   cfr_pkg::head_type head;
   logic              queue_full;
   logic              pop;

   cfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push)
   );

   cfr_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   cfr_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
